[sv/pgmh_pkg.sv]
package pgmh_pkg;

    localparam int POS_BITS      = 24;
    localparam int LEN_BITS      = POS_BITS + 1;
    localparam int SCAN_CMP_BITS = (POS_BITS > 16) ? POS_BITS : 16;
    localparam int PROD_BITS     = 32;
    localparam int DIFF_BITS     = ((LEN_BITS > PROD_BITS) ? LEN_BITS : PROD_BITS) + 1;
    localparam int VAL_BITS      = 16;
    localparam int OFFSET_BITS   = 24;

    localparam logic [7:0]  MAGIC_FIRST  = 8'h50;
    localparam logic [7:0]  MAGIC_SECOND = 8'h35;
    localparam logic [7:0]  COMMENT_MARK = 8'h23;
    localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;
    localparam logic [15:0] SCAN_LIMIT_RESET = 16'd2000;
    localparam logic [15:0] NUMBER_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_MAGIC  = 2'd1,
        STATUS_INCOMPLETE = 2'd2,
        STATUS_TOO_SHORT  = 2'd3
    } status_t;

    // header summary of one finished file
    typedef struct packed {
        status_t               status;
        logic [VAL_BITS-1:0]   image_width;
        logic [VAL_BITS-1:0]   image_height;
        logic [VAL_BITS-1:0]   max_value;
        logic [LEN_BITS-1:0]   length;
    } snap_t;

    typedef struct packed {
        snap_t                 snap;
        logic [PROD_BITS-1:0]  size;
    } prod_t;

endpackage

[sv/pgmh_parse.sv]
module pgmh_parse
    import pgmh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output logic        snap_valid,
    output snap_t       snap,
    input  logic        snap_ready
);

    logic [15:0]          scan_limit_reg;
    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic                 magic_reg, magic_next;
    logic                 in_comment_reg, in_comment_next;
    logic                 in_number_reg, in_number_next;
    logic [VAL_BITS-1:0]  acc_reg, acc_next;
    logic [1:0]           found_reg, found_next;
    logic [VAL_BITS-1:0]  values_reg [3];
    logic [VAL_BITS-1:0]  values_next [3];
    logic                 snap_valid_reg, snap_valid_next;
    snap_t                snap_reg, snap_next;

    logic                 accept;
    logic                 in_window;
    logic                 is_digit;
    logic                 commit;
    logic [19:0]          acc_wide;
    logic [LEN_BITS-1:0]  length;

    assign in_ready   = !snap_valid_reg || snap_ready;
    assign accept     = in_valid && in_ready;
    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    always_comb
    begin
        magic_next = magic_reg;
        if (pos_reg == '0 && data_byte != MAGIC_FIRST)
        begin
            magic_next = 1'b0;
        end
        if (pos_reg == POS_BITS'(1) && data_byte != MAGIC_SECOND)
        begin
            magic_next = 1'b0;
        end

        in_window = magic_next && (pos_reg >= POS_BITS'(3))
                    && (SCAN_CMP_BITS'(pos_reg) < SCAN_CMP_BITS'(scan_limit_reg))
                    && (found_reg != 2'd3);
        is_digit  = data_byte inside {[8'h30:8'h39]};
        // acc*10 + digit, at most 20 bits
        acc_wide  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + {16'h0000, data_byte[3:0]};

        in_comment_next = in_comment_reg;
        in_number_next  = in_number_reg;
        acc_next        = acc_reg;
        commit          = 1'b0;

        if (in_window)
        begin
            if (in_comment_reg)
            begin
                if (data_byte == NEWLINE_CHAR)
                begin
                    in_comment_next = 1'b0;
                end
            end
            else if (data_byte == COMMENT_MARK)
            begin
                commit          = in_number_reg;
                in_comment_next = 1'b1;
            end
            else if (is_digit)
            begin
                acc_next       = (acc_wide > 20'(NUMBER_MAX)) ? NUMBER_MAX : acc_wide[15:0];
                in_number_next = 1'b1;
            end
            else
            begin
                commit = in_number_reg;
            end
        end
        else if (in_comment_reg && data_byte == NEWLINE_CHAR)
        begin
            in_comment_next = 1'b0;
        end

        found_next = found_reg;
        if (commit)
        begin
            acc_next       = '0;
            in_number_next = 1'b0;
            found_next     = found_reg + 2'd1;
        end
        for (int i = 0; i < 3; i++)
        begin
            values_next[i] = (commit && found_reg == 2'(i)) ? acc_reg : values_reg[i];
        end

        pos_next = (pos_reg == '1) ? pos_reg : pos_reg + POS_BITS'(1);
        length   = LEN_BITS'(pos_reg) + LEN_BITS'(1);

        snap_next.image_width  = values_next[0];
        snap_next.image_height = values_next[1];
        snap_next.max_value    = values_next[2];
        snap_next.length       = length;
        if (!magic_next || pos_reg == '0)
        begin
            snap_next.status = STATUS_BAD_MAGIC;
        end
        else if (found_next != 2'd3)
        begin
            snap_next.status = STATUS_INCOMPLETE;
        end
        else
        begin
            snap_next.status = STATUS_OK;
        end

        if (accept && last_byte)
        begin
            snap_valid_next = 1'b1;
        end
        else if (snap_ready)
        begin
            snap_valid_next = 1'b0;
        end
        else
        begin
            snap_valid_next = snap_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_limit_reg <= SCAN_LIMIT_RESET;
            pos_reg        <= '0;
            magic_reg      <= 1'b1;
            in_comment_reg <= 1'b0;
            in_number_reg  <= 1'b0;
            acc_reg        <= '0;
            found_reg      <= '0;
            for (int i = 0; i < 3; i++)
            begin
                values_reg[i] <= '0;
            end
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                scan_limit_reg <= cfg_wdata;
            end
            snap_valid_reg <= snap_valid_next;
            if (accept)
            begin
                if (last_byte)
                begin
                    // start over for the next file
                    pos_reg        <= '0;
                    magic_reg      <= 1'b1;
                    in_comment_reg <= 1'b0;
                    in_number_reg  <= 1'b0;
                    acc_reg        <= '0;
                    found_reg      <= '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        values_reg[i] <= '0;
                    end
                end
                else
                begin
                    pos_reg        <= pos_next;
                    magic_reg      <= magic_next;
                    in_comment_reg <= in_comment_next;
                    in_number_reg  <= in_number_next;
                    acc_reg        <= acc_next;
                    found_reg      <= found_next;
                    for (int i = 0; i < 3; i++)
                    begin
                        values_reg[i] <= values_next[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
        begin
            snap_reg <= snap_next;
        end
    end

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=> (pos_reg == '0 && found_reg == 2'd0 && magic_reg))
        else $error("parse state not cleared after last item");
    a_done_no_number: assert property (@(posedge clk) disable iff (!rst_n)
        (found_reg == 2'd3) |-> !in_number_reg)
        else $error("number open after three numbers found");
    a_bad_magic_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !magic_reg |-> (found_reg == 2'd0 && acc_reg == '0))
        else $error("header parsed despite bad magic");
    a_snap_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        (snap_valid_reg && !$past(snap_valid_reg)) |-> $past(accept && last_byte))
        else $error("summary without last item");
`endif

endmodule

[sv/pgmh_mult.sv]
module pgmh_mult
    import pgmh_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  snap_valid,
    input  snap_t snap,
    output logic  snap_ready,
    output logic  prod_valid,
    output prod_t prod,
    input  logic  prod_ready
);

    logic  prod_valid_reg;
    prod_t prod_reg;

    assign snap_ready = !prod_valid_reg || prod_ready;
    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (snap_ready)
        begin
            prod_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_ready && snap_valid)
        begin
            prod_reg.snap <= snap;
            prod_reg.size <= PROD_BITS'(snap.image_width) * PROD_BITS'(snap.image_height);
        end
    end

`ifndef SYNTHESIS
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (prod_valid_reg && !prod_ready) |=> (prod_valid_reg && $stable(prod_reg)))
        else $error("product stage lost an item");
    a_size_match: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg |-> (prod_reg.size == PROD_BITS'(prod_reg.snap.image_width)
                            * PROD_BITS'(prod_reg.snap.image_height)))
        else $error("product does not match dimensions");
    a_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
        (prod_valid_reg && prod_reg.snap.status == STATUS_BAD_MAGIC) |-> prod_reg.size == '0)
        else $error("bad magic with nonzero size");
`endif

endmodule

[sv/pgmh_result.sv]
module pgmh_result
    import pgmh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   prod_valid,
    input  prod_t                  prod,
    output logic                   prod_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output status_t                status,
    output logic [VAL_BITS-1:0]    image_width,
    output logic [VAL_BITS-1:0]    image_height,
    output logic [VAL_BITS-1:0]    max_value,
    output logic [OFFSET_BITS-1:0] pixel_offset
);

    logic                   out_valid_reg;
    status_t                status_reg, status_next;
    logic [VAL_BITS-1:0]    width_reg, height_reg, maxv_reg;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [DIFF_BITS-1:0]   diff;

    assign prod_ready   = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign image_width  = width_reg;
    assign image_height = height_reg;
    assign max_value    = maxv_reg;
    assign pixel_offset = offset_reg;

    always_comb
    begin
        diff        = DIFF_BITS'(prod.snap.length) - DIFF_BITS'(prod.size);
        status_next = prod.snap.status;
        offset_next = '0;
        if (prod.snap.status == STATUS_OK)
        begin
            // borrow or zero means the file has no room for the pixels
            if (diff[DIFF_BITS-1] || diff == '0)
            begin
                status_next = STATUS_TOO_SHORT;
            end
            else
            begin
                offset_next = diff[OFFSET_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (prod_ready)
        begin
            out_valid_reg <= prod_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready && prod_valid)
        begin
            status_reg <= status_next;
            width_reg  <= prod.snap.image_width;
            height_reg <= prod.snap.image_height;
            maxv_reg   <= prod.snap.max_value;
            offset_reg <= offset_next;
        end
    end

`ifndef SYNTHESIS
    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != STATUS_OK) |-> offset_reg == '0)
        else $error("offset set on failed header");
    a_bad_magic_dims: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == STATUS_BAD_MAGIC)
        |-> (width_reg == '0 && height_reg == '0 && maxv_reg == '0))
        else $error("dimensions reported with bad magic");
    a_load_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (prod_valid && prod_ready) |=> out_valid_reg)
        else $error("result stage dropped an item");
`endif

endmodule

[sv/pgm_header_parser_unit.sv]
// pgm header parser: takes the bytes of a binary greyscale image file on the
// s_axis channel, one item per byte (tdata = byte, tlast = final byte of file)
// and gives one result item on m_axis per file, after its final byte.
// the result holds status, width, height, maximum value and the pixel offset
// (file length minus width*height, valid when status is ok).
// cfg_we / cfg_wdata write the scan limit (reset 2000); write only when idle.
// throughput: one byte item per cycle while the summary register can move on;
// the parse state updates in the cycle the item is accepted.
// the result is registered in turn in the summary register, the width*height
// multiplier register and the result register after the final byte is accepted.
// reset clears all parse state and the pipeline; the scan limit goes to 2000.
// when m_axis stalls, results wait in the three registers; once the summary
// register is full and cannot move on, s_axis stops taking any byte.
module pgm_header_parser_unit
    import pgmh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // status, image_width, image_height,
                                        // max_value, pixel_offset, zero pad
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic                   snap_valid, snap_ready;
    snap_t                  snap;
    logic                   prod_valid, prod_ready;
    prod_t                  prod;
    status_t                status;
    logic [VAL_BITS-1:0]    image_width, image_height, max_value;
    logic [OFFSET_BITS-1:0] pixel_offset;

    pgmh_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .data_byte  (s_axis_tdata),
        .last_byte  (s_axis_tlast),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready)
    );

    pgmh_mult u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready),
        .prod_valid (prod_valid),
        .prod       (prod),
        .prod_ready (prod_ready)
    );

    pgmh_result u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .prod_valid   (prod_valid),
        .prod         (prod),
        .prod_ready   (prod_ready),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .status       (status),
        .image_width  (image_width),
        .image_height (image_height),
        .max_value    (max_value),
        .pixel_offset (pixel_offset)
    );

    assign m_axis_tdata = {6'b000000, pixel_offset, max_value, image_height,
                           image_width, status};

endmodule

[test/pgm_header_parser_unit_tb.sv]
module pgm_header_parser_unit_tb;
    import pgmh_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_GAP     = 17;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 4;

    typedef struct {
        status_t     status;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] maxval;
        logic [23:0] offset;
    } header_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_byte
    logic        s_axis_tlast;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // status, image_width, image_height,
                                 // max_value, pixel_offset, zero pad
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    pgm_header_parser_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // header parse state mirrored from the block
    logic [23:0]    hdr_pos;
    logic           magic_ok;
    logic           skipping_comment;
    logic           digits_open;
    int unsigned    digit_acc;
    int             n_found;
    logic [15:0]    hdr_val [3];
    logic [15:0]    scan_lim;

    header_result_t expected_headers [$];
    logic [7:0]     frame_q [$];

    int  errors;
    int  cycles;
    int  bytes_sent;
    int  hold_req;
    bit  src_idle;
    bit  sink_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycles <= cycles + 1;

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("** pgm_header_parser_unit: FAILED **");
        $finish;
    end

    function automatic void clear_parse();
        hdr_pos          = '0;
        magic_ok         = 1'b1;
        skipping_comment = 1'b0;
        digits_open      = 1'b0;
        digit_acc        = 0;
        n_found          = 0;
        for (int i = 0; i < 3; i++)
            hdr_val[i] = '0;
    endfunction

    function automatic void close_number();
        if (n_found < 3)
        begin
            hdr_val[n_found] = digit_acc[15:0];
            n_found++;
        end
        digit_acc   = 0;
        digits_open = 1'b0;
    endfunction

    function automatic void parse_hdr_byte(logic [7:0] b);
        int unsigned v;
        if (skipping_comment)
        begin
            if (b == NEWLINE_CHAR)
                skipping_comment = 1'b0;
        end
        else if (b == COMMENT_MARK)
        begin
            if (digits_open)
                close_number();
            skipping_comment = 1'b1;
        end
        else if (b >= "0" && b <= "9")
        begin
            v = digit_acc * 10 + (b - "0");
            digit_acc   = (v > NUMBER_MAX) ? NUMBER_MAX : v;
            digits_open = 1'b1;
        end
        else if (digits_open)
            close_number();
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic last);
        logic [23:0]     pos;
        longint unsigned file_len;
        longint unsigned area;
        header_result_t  r;
        pos = hdr_pos;
        if (pos == 0 && b != MAGIC_FIRST)
            magic_ok = 1'b0;
        if (pos == 1 && b != MAGIC_SECOND)
            magic_ok = 1'b0;
        if (magic_ok && pos >= 3 && pos < scan_lim && n_found < 3)
            parse_hdr_byte(b);
        else if (skipping_comment && b == NEWLINE_CHAR)
            skipping_comment = 1'b0;
        if (hdr_pos != 24'hFFFFFF)
            hdr_pos = hdr_pos + 1'b1;
        if (last)
        begin
            file_len = longint'(pos) + 1;
            area     = longint'(hdr_val[0]) * longint'(hdr_val[1]);
            r.offset = '0;
            if (!magic_ok || file_len < 2)
                r.status = STATUS_BAD_MAGIC;
            else if (n_found < 3)
                r.status = STATUS_INCOMPLETE;
            else if (file_len <= area)
                r.status = STATUS_TOO_SHORT;
            else
            begin
                r.status = STATUS_OK;
                r.offset = 24'(file_len - area);
            end
            r.width  = hdr_val[0];
            r.height = hdr_val[1];
            r.maxval = hdr_val[2];
            expected_headers.push_back(r);
            clear_parse();
        end
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        header_result_t r;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_headers.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, m_axis_tdata);
            end
            else
            begin
                r = expected_headers.pop_front();
                check_field("status", r.status, m_axis_tdata[1:0]);
                check_field("image_width", r.width, m_axis_tdata[17:2]);
                check_field("image_height", r.height, m_axis_tdata[33:18]);
                check_field("max_value", r.maxval, m_axis_tdata[49:34]);
                check_field("pixel_offset", r.offset, m_axis_tdata[73:50]);
            end
        end
    end

    // result side: random stall per item while sink_idle is set, or one long hold when asked
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (hold_req > 0)
            begin
                stall    = hold_req;
                hold_req = 0;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid && hold_req == 0);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        predict_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
        frame_q.delete();
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_headers.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_scan_limit(input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        scan_lim  = v;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            frame_q.push_back(s[i]);
    endtask

    task automatic push_number(input int unsigned v);
        if ($urandom_range(0, 7) == 0)
            push_text("00");
        push_text($sformatf("%0d", v));
    endtask

    task automatic push_separator();
        int         kind;
        int         n;
        logic [7:0] b;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            n = $urandom_range(1, 2);
            repeat (n)
                case ($urandom_range(0, 3))
                    0: frame_q.push_back(" ");
                    1: frame_q.push_back(8'h09);
                    2: frame_q.push_back(NEWLINE_CHAR);
                    default: frame_q.push_back(8'h0D);
                endcase
        end
        else if (kind <= 7)
        begin
            do b = 8'($urandom_range(0, 255));
            while ((b >= "0" && b <= "9") || b == COMMENT_MARK);
            frame_q.push_back(b);
        end
        else
        begin
            // comment body may hold digits and further marks
            frame_q.push_back(COMMENT_MARK);
            n = $urandom_range(0, 5);
            repeat (n)
            begin
                do b = 8'($urandom_range(0, 255));
                while (b == NEWLINE_CHAR);
                frame_q.push_back(b);
            end
            frame_q.push_back(NEWLINE_CHAR);
        end
    endtask

    function automatic int unsigned pick_dim();
        return ($urandom_range(0, 11) == 0) ? $urandom_range(6, 99999) : $urandom_range(0, 5);
    endfunction

    task automatic build_random_frame();
        int          roll;
        int          n;
        int unsigned w;
        int unsigned h;
        longint      area;
        roll = $urandom_range(0, 99);
        frame_q.delete();
        if (roll < 12)
        begin
            if ($urandom_range(0, 1))
            begin
                frame_q.push_back(MAGIC_FIRST);
                frame_q.push_back($urandom_range(0, 1) ? MAGIC_SECOND : 8'($urandom_range(0, 255)));
            end
            n = $urandom_range(1, 12);
            repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            frame_q.push_back(MAGIC_FIRST);
            frame_q.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                            : MAGIC_SECOND);
            frame_q.push_back(8'($urandom_range(0, 255)));
            w = pick_dim();
            h = pick_dim();
            push_separator();
            push_number(w);
            push_separator();
            push_number(h);
            push_separator();
            push_number(($urandom_range(0, 3) == 0) ? $urandom_range(0, 99999) : 255);
            push_separator();
            area = longint'(w > NUMBER_MAX ? NUMBER_MAX : w)
                 * longint'(h > NUMBER_MAX ? NUMBER_MAX : h);
            if (area > 40)
                n = $urandom_range(0, 8);
            else if ($urandom_range(0, 5) == 0)
                n = $urandom_range(0, int'(area));
            else
                n = int'(area) + $urandom_range(0, 3);
            repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
            // cut the file short somewhere in the header or pixels
            if (roll < 22)
                while (frame_q.size() > 1 && frame_q.size() > $urandom_range(1, 20))
                    void'(frame_q.pop_back());
        end
    endtask

    task automatic test_directed();
        push_text("Q");
        send_frame();
        push_text("P");
        send_frame();
        // '#' closes the width, comment runs to newline
        push_text("P5x1#\n2 9 ");
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hFF);
        frame_q.push_back(8'h80);
        send_frame();
        push_text("P5 7 8");
        send_frame();
        push_text("P5 9 9 1 ");
        send_frame();
        drain();
    endtask

    task automatic test_backpressure();
        src_idle = 1'b0;
        hold_req = LONG_HOLD;
        repeat (6)
        begin
            push_text("P5\n2 2 7 ");
            repeat (5) frame_q.push_back(8'($urandom_range(0, 255)));
            send_frame();
        end
        drain();
        src_idle = 1'b1;
    endtask

    task automatic test_scan_window();
        logic [15:0] limits [5];
        limits[0] = 16'd4;
        limits[1] = 16'hFFFF;
        limits[2] = 16'($urandom_range(5, 30));
        limits[3] = 16'($urandom_range(31, 65534));
        limits[4] = SCAN_LIMIT_RESET;
        foreach (limits[k])
        begin
            write_scan_limit(limits[k]);
            repeat (3)
            begin
                build_random_frame();
                send_frame();
            end
            drain();
        end
    endtask

    task automatic test_random();
        int frames;
        frames = 0;
        while (bytes_sent < 850 || frames < 10)
        begin
            if (frames % 5 == 0)
            begin
                src_idle  = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
            end
            build_random_frame();
            send_frame();
            frames++;
        end
        drain();
    endtask

    initial
    begin
        errors     = 0;
        cycles     = 0;
        bytes_sent = 0;
        hold_req   = 0;
        src_idle   = 1'b1;
        sink_idle  = 1'b1;
        scan_lim   = SCAN_LIMIT_RESET;
        clear_parse();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_scan_window();
        test_random();

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("** pgm_header_parser_unit: PASSED **");
        else
            $display("** pgm_header_parser_unit: FAILED **");
        $finish;
    end

endmodule
